### hw/rtl/rbfr_pkg.sv
// Shared types, widths and constants of the RGB565 box filter resizer.
package rbfr_pkg;

  // Field and register widths
  localparam int SW_W     = 10;  // source size registers
  localparam int DW_W     = 9;   // destination size registers
  localparam int DCOORD_W = 8;   // destination coordinates
  localparam int SCOORD_W = 9;   // source coordinates
  localparam int PIX_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Register reset values
  localparam int SRC_WIDTH_RESET  = 480;
  localparam int SRC_HEIGHT_RESET = 480;
  localparam int DST_WIDTH_RESET  = 240;
  localparam int DST_HEIGHT_RESET = 240;

  // Default size limits
  localparam int MAX_SRC_W_DEF = 512;
  localparam int MAX_SRC_H_DEF = 512;
  localparam int MAX_DST_W_DEF = 256;
  localparam int MAX_DST_H_DEF = 256;

  // Bound divider: (i * src) / dst, quotient never exceeds src
  localparam int SPAN_PROD_W = DW_W + SW_W;
  localparam int SPAN_Q_W    = SW_W;
  localparam int SPAN_LANES  = 4;
  localparam int SPAN_X_LO   = 0;
  localparam int SPAN_X_HI   = 1;
  localparam int SPAN_Y_LO   = 2;
  localparam int SPAN_Y_HI   = 3;

  // Channel divider: sum / count, quotient never exceeds the channel maximum
  localparam int CH_Q_W   = 6;
  localparam int CH_LANES = 3;
  localparam int CH_R     = 0;
  localparam int CH_G     = 1;
  localparam int CH_B     = 2;

  localparam int STEP_W = 4;

  // RGB565 packing
  localparam int RED_LSB = 11;
  localparam int GRN_LSB = 5;
  localparam logic [4:0] RED_MASK = 5'h1F;
  localparam logic [5:0] GRN_MASK = 6'h3F;
  localparam logic [4:0] BLU_MASK = 5'h1F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ACTION_LOAD    = 1'b0,
    ACTION_COMPUTE = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPAN,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_AVG_LOAD,
    ST_AVG,
    ST_OUT
  } state_t;

endpackage

### hw/rtl/rgb565_box_filter_resizer.sv
// Top level of the RGB565 box filter resizer: pixel store, bound and channel dividers.
//
// The block keeps a MAX_SRC_W x MAX_SRC_H RGB565 image in one synchronous
// single-port-per-direction store (one write, one registered read a cycle),
// addressed row * MAX_SRC_W + col. The store is not cleared at reset; every
// source pixel that a compute request can cover must be loaded first. Loads
// may follow each other in every cycle while the block is idle; a load
// outside the configured source size is dropped. A compute request that lies
// inside the destination size forms the products, runs the radix-2 bound
// divider (four lanes at once), makes one store read per source pixel in its
// box and runs the radix-2 channel divider (three lanes at once). A compute
// request outside the destination size returns zero with in_range low. One
// request is in work at a time; a finished result waits in the output
// register, and the block holds its next result until that register is free.
// Size registers must be written only while the block is idle; the block
// itself does not enforce this. A zero size acts as one and a size above its
// maximum acts as that maximum.
module rgb565_box_filter_resizer #(
  parameter int MAX_SRC_W = rbfr_pkg::MAX_SRC_W_DEF,
  parameter int MAX_SRC_H = rbfr_pkg::MAX_SRC_H_DEF,
  parameter int MAX_DST_W = rbfr_pkg::MAX_DST_W_DEF,
  parameter int MAX_DST_H = rbfr_pkg::MAX_DST_H_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [rbfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [rbfr_pkg::SCOORD_W-1:0]     src_col,
  input  logic [rbfr_pkg::SCOORD_W-1:0]     src_row,
  input  logic [rbfr_pkg::PIX_W-1:0]        src_pixel,
  input  logic [rbfr_pkg::DCOORD_W-1:0]     dst_col,
  input  logic [rbfr_pkg::DCOORD_W-1:0]     dst_row,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rbfr_pkg::PIX_W-1:0]        dst_pixel,
  output logic                              in_range
);

  localparam int SW_W   = rbfr_pkg::SW_W;
  localparam int DW_W   = rbfr_pkg::DW_W;
  localparam int DEPTH  = MAX_SRC_W * MAX_SRC_H;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + rbfr_pkg::CH_Q_W;
  localparam int SQ_W   = rbfr_pkg::SPAN_Q_W;
  localparam int CQ_W   = rbfr_pkg::CH_Q_W;
  localparam int PR_W   = rbfr_pkg::SPAN_PROD_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SW_W-1:0] src_width;
  logic [SW_W-1:0] src_height;
  logic [DW_W-1:0] dst_width;
  logic [DW_W-1:0] dst_height;

  // Write a size register
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SW_W'(rbfr_pkg::SRC_WIDTH_RESET);
      src_height <= SW_W'(rbfr_pkg::SRC_HEIGHT_RESET);
      dst_width  <= DW_W'(rbfr_pkg::DST_WIDTH_RESET);
      dst_height <= DW_W'(rbfr_pkg::DST_HEIGHT_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        rbfr_pkg::CFG_SRC_WIDTH:  src_width  <= cfg_data[SW_W-1:0];
        rbfr_pkg::CFG_SRC_HEIGHT: src_height <= cfg_data[SW_W-1:0];
        rbfr_pkg::CFG_DST_WIDTH:  dst_width  <= cfg_data[DW_W-1:0];
        rbfr_pkg::CFG_DST_HEIGHT: dst_height <= cfg_data[DW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, above the maximum acts as the maximum
  logic [SW_W-1:0] sw_eff;
  logic [SW_W-1:0] sh_eff;
  logic [DW_W-1:0] dw_eff;
  logic [DW_W-1:0] dh_eff;

  always_comb begin
    sw_eff = (src_width == '0) ? SW_W'(1) :
             ((32'(src_width) > MAX_SRC_W) ? SW_W'(MAX_SRC_W) : src_width);
    sh_eff = (src_height == '0) ? SW_W'(1) :
             ((32'(src_height) > MAX_SRC_H) ? SW_W'(MAX_SRC_H) : src_height);
    dw_eff = (dst_width == '0) ? DW_W'(1) :
             ((32'(dst_width) > MAX_DST_W) ? DW_W'(MAX_DST_W) : dst_width);
    dh_eff = (dst_height == '0) ? DW_W'(1) :
             ((32'(dst_height) > MAX_DST_H) ? DW_W'(MAX_DST_H) : dst_height);
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  rbfr_pkg::state_t state;
  rbfr_pkg::state_t state_next;

  logic                          in_fire;
  logic                          is_load;
  logic                          ld_ok;
  logic                          dst_ok;
  logic [rbfr_pkg::STEP_W-1:0]   step;
  logic                          span_done;
  logic                          avg_done;
  logic                          last_col;
  logic                          last_row;
  logic                          out_load;
  logic                          rd_en;
  logic                          oor;

  assign in_fire = in_valid && in_ready;
  assign is_load = (rbfr_pkg::action_t'(action) == rbfr_pkg::ACTION_LOAD);
  assign ld_ok   = ({1'b0, src_col} < sw_eff) && ({1'b0, src_row} < sh_eff);
  assign dst_ok  = ({1'b0, dst_col} < dw_eff) && ({1'b0, dst_row} < dh_eff);
  assign span_done = (step == rbfr_pkg::STEP_W'(SQ_W - 1));
  assign avg_done  = (step == rbfr_pkg::STEP_W'(CQ_W - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rbfr_pkg::ST_IDLE: begin
        if (in_fire && !is_load) begin
          state_next = dst_ok ? rbfr_pkg::ST_MUL : rbfr_pkg::ST_OUT;
        end
      end
      rbfr_pkg::ST_MUL:      state_next = rbfr_pkg::ST_SPAN;
      rbfr_pkg::ST_SPAN:     if (span_done) state_next = rbfr_pkg::ST_SETUP;
      rbfr_pkg::ST_SETUP:    state_next = rbfr_pkg::ST_READ;
      rbfr_pkg::ST_READ:     if (last_col && last_row) state_next = rbfr_pkg::ST_DRAIN;
      rbfr_pkg::ST_DRAIN:    state_next = rbfr_pkg::ST_AVG_LOAD;
      rbfr_pkg::ST_AVG_LOAD: state_next = rbfr_pkg::ST_AVG;
      rbfr_pkg::ST_AVG:      if (avg_done) state_next = rbfr_pkg::ST_OUT;
      rbfr_pkg::ST_OUT:      if (!out_valid || out_ready) state_next = rbfr_pkg::ST_IDLE;
      default:               state_next = rbfr_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = (state == rbfr_pkg::ST_IDLE);
    rd_en    = (state == rbfr_pkg::ST_READ);
    out_load = (state == rbfr_pkg::ST_OUT) && (!out_valid || out_ready);
  end

  // Advance state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbfr_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == rbfr_pkg::ST_SPAN || state == rbfr_pkg::ST_AVG) begin
        step <= step + rbfr_pkg::STEP_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  // Hold the request coordinates
  logic [rbfr_pkg::DCOORD_W-1:0] x_reg;
  logic [rbfr_pkg::DCOORD_W-1:0] y_reg;

  always_ff @(posedge clk) begin
    if (in_fire && !is_load) begin
      x_reg <= dst_col;
      y_reg <= dst_row;
      oor   <= !dst_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Bound divider: four lanes, one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [DW_W-1:0] sp_rem      [rbfr_pkg::SPAN_LANES];
  logic [SQ_W-1:0] sp_quo      [rbfr_pkg::SPAN_LANES];
  logic [DW_W-1:0] sp_div      [rbfr_pkg::SPAN_LANES];
  logic [PR_W-1:0] sp_prod     [rbfr_pkg::SPAN_LANES];
  logic [DW_W-1:0] sp_rem_next [rbfr_pkg::SPAN_LANES];
  logic [SQ_W-1:0] sp_quo_next [rbfr_pkg::SPAN_LANES];

  always_comb begin
    sp_div[rbfr_pkg::SPAN_X_LO]  = dw_eff;
    sp_div[rbfr_pkg::SPAN_X_HI]  = dw_eff;
    sp_div[rbfr_pkg::SPAN_Y_LO]  = dh_eff;
    sp_div[rbfr_pkg::SPAN_Y_HI]  = dh_eff;
    sp_prod[rbfr_pkg::SPAN_X_LO] = PR_W'(x_reg) * PR_W'(sw_eff);
    sp_prod[rbfr_pkg::SPAN_X_HI] = (PR_W'(x_reg) + PR_W'(1)) * PR_W'(sw_eff);
    sp_prod[rbfr_pkg::SPAN_Y_LO] = PR_W'(y_reg) * PR_W'(sh_eff);
    sp_prod[rbfr_pkg::SPAN_Y_HI] = (PR_W'(y_reg) + PR_W'(1)) * PR_W'(sh_eff);
  end

  // Shift in one dividend bit and subtract where it fits
  always_comb begin
    logic [DW_W:0] t;
    for (int l = 0; l < rbfr_pkg::SPAN_LANES; l++) begin
      t = {sp_rem[l], sp_quo[l][SQ_W-1]};
      if (t >= {1'b0, sp_div[l]}) begin
        sp_rem_next[l] = DW_W'(t - {1'b0, sp_div[l]});
        sp_quo_next[l] = {sp_quo[l][SQ_W-2:0], 1'b1};
      end else begin
        sp_rem_next[l] = t[DW_W-1:0];
        sp_quo_next[l] = {sp_quo[l][SQ_W-2:0], 1'b0};
      end
    end
  end

  // Load products, then iterate
  always_ff @(posedge clk) begin
    for (int l = 0; l < rbfr_pkg::SPAN_LANES; l++) begin
      if (state == rbfr_pkg::ST_MUL) begin
        sp_rem[l] <= sp_prod[l][PR_W-1:SQ_W];
        sp_quo[l] <= sp_prod[l][SQ_W-1:0];
      end else if (state == rbfr_pkg::ST_SPAN) begin
        sp_rem[l] <= sp_rem_next[l];
        sp_quo[l] <= sp_quo_next[l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Box walk
  // ---------------------------------------------------------------------------
  logic [SW_W-1:0]   x0;
  logic [SW_W-1:0]   x_end;
  logic [SW_W-1:0]   y_end;
  logic [SW_W-1:0]   xx;
  logic [SW_W-1:0]   yy;
  logic [SW_W-1:0]   xx_inc;
  logic [SW_W-1:0]   yy_inc;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] rd_addr;
  logic [SW_W-1:0]   xh_fix;
  logic [SW_W-1:0]   yh_fix;

  assign xx_inc   = xx + SW_W'(1);
  assign yy_inc   = yy + SW_W'(1);
  assign last_col = (xx_inc == x_end);
  assign last_row = (yy_inc == y_end);
  assign rd_addr  = row_base + ADDR_W'(xx);

  // Widen an empty span to one pixel and clamp it to the source edge
  always_comb begin
    xh_fix = sp_quo[rbfr_pkg::SPAN_X_HI];
    if (xh_fix <= sp_quo[rbfr_pkg::SPAN_X_LO]) begin
      xh_fix = sp_quo[rbfr_pkg::SPAN_X_LO] + SW_W'(1);
    end
    if (xh_fix > sw_eff) begin
      xh_fix = sw_eff;
    end
    yh_fix = sp_quo[rbfr_pkg::SPAN_Y_HI];
    if (yh_fix <= sp_quo[rbfr_pkg::SPAN_Y_LO]) begin
      yh_fix = sp_quo[rbfr_pkg::SPAN_Y_LO] + SW_W'(1);
    end
    if (yh_fix > sh_eff) begin
      yh_fix = sh_eff;
    end
  end

  // Set up the walk, then advance column by column, row by row
  always_ff @(posedge clk) begin
    if (state == rbfr_pkg::ST_SETUP) begin
      x0       <= sp_quo[rbfr_pkg::SPAN_X_LO];
      xx       <= sp_quo[rbfr_pkg::SPAN_X_LO];
      yy       <= sp_quo[rbfr_pkg::SPAN_Y_LO];
      x_end    <= xh_fix;
      y_end    <= yh_fix;
      row_base <= ADDR_W'(32'(sp_quo[rbfr_pkg::SPAN_Y_LO]) * MAX_SRC_W);
    end else if (rd_en) begin
      if (last_col) begin
        xx       <= x0;
        yy       <= yy_inc;
        row_base <= row_base + ADDR_W'(MAX_SRC_W);
      end else begin
        xx <= xx_inc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel store
  // ---------------------------------------------------------------------------
  logic [rbfr_pkg::PIX_W-1:0] store [DEPTH];
  logic [rbfr_pkg::PIX_W-1:0] rd_data;
  logic [ADDR_W-1:0]          ld_addr;
  logic                       rd_vld;

  assign ld_addr = ADDR_W'(32'(src_row) * MAX_SRC_W + 32'(src_col));

  // Write loads, read one box pixel a cycle
  always_ff @(posedge clk) begin
    if (in_fire && is_load && ld_ok) begin
      store[ld_addr] <= src_pixel;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel sums
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum [rbfr_pkg::CH_LANES];
  logic [CNT_W-1:0] cnt;

  // Clear at setup, add each returned pixel
  always_ff @(posedge clk) begin
    if (state == rbfr_pkg::ST_SETUP) begin
      for (int c = 0; c < rbfr_pkg::CH_LANES; c++) begin
        sum[c] <= '0;
      end
      cnt <= '0;
    end else if (rd_vld) begin
      sum[rbfr_pkg::CH_R] <= sum[rbfr_pkg::CH_R]
          + SUM_W'(rd_data[rbfr_pkg::RED_LSB +: 5] & rbfr_pkg::RED_MASK);
      sum[rbfr_pkg::CH_G] <= sum[rbfr_pkg::CH_G]
          + SUM_W'(rd_data[rbfr_pkg::GRN_LSB +: 6] & rbfr_pkg::GRN_MASK);
      sum[rbfr_pkg::CH_B] <= sum[rbfr_pkg::CH_B]
          + SUM_W'(rd_data[4:0] & rbfr_pkg::BLU_MASK);
      cnt <= cnt + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Channel divider: three lanes, one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] ch_rem      [rbfr_pkg::CH_LANES];
  logic [CQ_W-1:0]  ch_quo      [rbfr_pkg::CH_LANES];
  logic [CNT_W-1:0] ch_rem_next [rbfr_pkg::CH_LANES];
  logic [CQ_W-1:0]  ch_quo_next [rbfr_pkg::CH_LANES];

  always_comb begin
    logic [CNT_W:0] t;
    for (int c = 0; c < rbfr_pkg::CH_LANES; c++) begin
      t = {ch_rem[c], ch_quo[c][CQ_W-1]};
      if (t >= {1'b0, cnt}) begin
        ch_rem_next[c] = CNT_W'(t - {1'b0, cnt});
        ch_quo_next[c] = {ch_quo[c][CQ_W-2:0], 1'b1};
      end else begin
        ch_rem_next[c] = t[CNT_W-1:0];
        ch_quo_next[c] = {ch_quo[c][CQ_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < rbfr_pkg::CH_LANES; c++) begin
      if (state == rbfr_pkg::ST_AVG_LOAD) begin
        ch_rem[c] <= sum[c][SUM_W-1:CQ_W];
        ch_quo[c] <= sum[c][CQ_W-1:0];
      end else if (state == rbfr_pkg::ST_AVG) begin
        ch_rem[c] <= ch_rem_next[c];
        ch_quo[c] <= ch_quo_next[c];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Repack the averages, or zero for a request outside the destination
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (oor) begin
        dst_pixel <= '0;
        in_range  <= 1'b0;
      end else begin
        dst_pixel <= {ch_quo[rbfr_pkg::CH_R][4:0] & rbfr_pkg::RED_MASK,
                      ch_quo[rbfr_pkg::CH_G][5:0] & rbfr_pkg::GRN_MASK,
                      ch_quo[rbfr_pkg::CH_B][4:0] & rbfr_pkg::BLU_MASK};
        in_range  <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // Read data shows up only in the cycle after a box read
  a_rd_latency: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == rbfr_pkg::ST_READ)
    else $error("store read data without a preceding box read");

  // Box walk stays inside its bounds and inside the source
  a_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == rbfr_pkg::ST_READ) |->
      (xx < x_end) && (yy < y_end) && (x_end <= sw_eff) && (y_end <= sh_eff))
    else $error("box walk out of bounds");

  // Every box holds at least one pixel before averaging
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == rbfr_pkg::ST_AVG_LOAD) |-> (cnt != '0))
    else $error("empty box reached the channel divider");

  // Red and blue averages fit five bits
  a_avg_width: assert property (@(posedge clk) disable iff (rst)
    (state == rbfr_pkg::ST_OUT && !oor) |->
      (ch_quo[rbfr_pkg::CH_R][5] == 1'b0) && (ch_quo[rbfr_pkg::CH_B][5] == 1'b0))
    else $error("channel average overflow");

  // A compute request closes the input until its result is placed
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !is_load) |=> !in_ready)
    else $error("request accepted while a compute is in work");
`endif

endmodule
